### rtl/srtf_preemptive_scheduler_top_macros.svh
// ----------------------------------------------------------------------------
// SRTF scheduler assertion macros
// Shorthand for the concurrent checks used in the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef SRTF_PREEMPTIVE_SCHEDULER_TOP_MACROS_SVH
`define SRTF_PREEMPTIVE_SCHEDULER_TOP_MACROS_SVH

// cons must hold in the same cycle as ante
`define SRTF_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srtf: implication check failed");

// expr must never be true
`define SRTF_ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("srtf: forbidden condition seen");

// cons must hold in the cycle after ante
`define SRTF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srtf: next-cycle check failed");

`endif

### rtl/srtf_pkg.sv
// ----------------------------------------------------------------------------
// SRTF scheduler package
// Sizes, opcodes, sequencer states and the structs shared by cells and
// sequencer.
// ----------------------------------------------------------------------------
package srtf_pkg;

  localparam int SLOTS        = 16;
  localparam int TIME_WIDTH   = 16;
  localparam int IDX_W        = $clog2(SLOTS);
  localparam int OP_W         = 2;
  localparam int SLOT_FIELD_W = 4;
  localparam int FIELD_W      = 16;

  localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

  typedef logic [TIME_WIDTH-1:0] time_t;
  typedef logic [IDX_W-1:0]      idx_t;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_TICK  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_EMIT
  } state_e;

  // best-so-far candidate travelling down the cell row
  typedef struct packed {
    logic  found;
    time_t rem;
    time_t arr;
    time_t burst;
    idx_t  idx;
  } cand_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic  load;
    logic  clear;
    logic  dec;
    idx_t  wr_slot;
    idx_t  dec_slot;
    time_t arrival;
    time_t burst;
    time_t now;
  } cell_ctl_t;

endpackage

### rtl/srtf_cell.sv
// ----------------------------------------------------------------------------
// SRTF slot cell
// Holds one process slot and merges itself into the passing candidate.
// ----------------------------------------------------------------------------
module srtf_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  srtf_pkg::idx_t       idx,
  input  srtf_pkg::cell_ctl_t  ctl,
  input  logic                 cin_valid,
  input  srtf_pkg::cand_t      cin,
  output logic                 cout_valid,
  output srtf_pkg::cand_t      cout
);

  srtf_pkg::time_t arr;
  srtf_pkg::time_t burst;
  srtf_pkg::time_t rem;
  logic            ready;
  logic            take;
  srtf_pkg::cand_t cand_next;

  // slot state; only remaining time needs clearing, empty slots are never read
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (ctl.clear) begin
      rem <= '0;
    end else if (ctl.load && ctl.wr_slot == idx) begin
      rem <= ctl.burst;
    end else if (ctl.dec && ctl.dec_slot == idx) begin
      rem <= rem - srtf_pkg::time_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load && ctl.wr_slot == idx) begin
      arr   <= ctl.arrival;
      burst <= ctl.burst;
    end
  end

  // ties: earlier arrival wins, then the lower slot (already upstream)
  always_comb begin
    ready = (rem != '0) && (arr <= ctl.now);
    take  = ready && (!cin.found || (rem < cin.rem) ||
                      ((rem == cin.rem) && (arr < cin.arr)));
    if (take) begin
      cand_next = '{found: 1'b1, rem: rem, arr: arr, burst: burst, idx: idx};
    end else begin
      cand_next = cin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cout_valid <= 1'b0;
    end else begin
      cout_valid <= cin_valid;
    end
  end

  always_ff @(posedge clk) begin
    cout <= cand_next;
  end

endmodule

### rtl/srtf_seq.sv
// ----------------------------------------------------------------------------
// SRTF sequencer
// Takes items, drives the cell row, works out the result and holds it in
// the output register.
// ----------------------------------------------------------------------------
`include "srtf_preemptive_scheduler_top_macros.svh"

module srtf_seq (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [srtf_pkg::OP_W-1:0]             in_opcode,
  input  logic [srtf_pkg::SLOT_FIELD_W-1:0]     in_slot,
  input  logic [srtf_pkg::FIELD_W-1:0]          in_arrival,
  input  logic [srtf_pkg::FIELD_W-1:0]          in_burst,
  output logic                                  head_valid,
  output srtf_pkg::cand_t                       head,
  input  logic                                  tail_valid,
  input  srtf_pkg::cand_t                       tail,
  output srtf_pkg::cell_ctl_t                   ctl,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_ran,
  output logic [srtf_pkg::SLOT_FIELD_W-1:0]     out_slot,
  output logic                                  out_finished,
  output logic [srtf_pkg::FIELD_W-1:0]          out_finish_time,
  output logic [srtf_pkg::FIELD_W-1:0]          out_turnaround,
  output logic [srtf_pkg::FIELD_W-1:0]          out_waiting,
  output logic [srtf_pkg::FIELD_W-1:0]          out_time_now
);

  srtf_pkg::state_e state;
  srtf_pkg::state_e state_next;
  srtf_pkg::time_t  cur_time;
  srtf_pkg::time_t  time_inc;
  srtf_pkg::cand_t  best;
  logic             res_ran;
  logic             res_fin;
  srtf_pkg::idx_t   res_slot;
  srtf_pkg::time_t  res_fin_time;
  srtf_pkg::time_t  res_tat;
  srtf_pkg::time_t  res_time_now;
  srtf_pkg::time_t  tat_calc;
  srtf_pkg::time_t  wait_calc;
  srtf_pkg::op_e    op;
  logic             accept;
  logic             out_free;
  logic             slot_ok;

  assign op       = srtf_pkg::op_e'(in_opcode);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign slot_ok  = 32'(in_slot) < srtf_pkg::SLOTS;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srtf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      srtf_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (op == srtf_pkg::OP_TICK) ? srtf_pkg::ST_SCAN : srtf_pkg::ST_EMIT;
        end
      end
      srtf_pkg::ST_SCAN: begin
        if (tail_valid) begin
          state_next = srtf_pkg::ST_CALC;
        end
      end
      srtf_pkg::ST_CALC: state_next = srtf_pkg::ST_EMIT;
      srtf_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = srtf_pkg::ST_IDLE;
        end
      end
      default: state_next = srtf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state == srtf_pkg::ST_IDLE);
    head_valid = (state == srtf_pkg::ST_IDLE) && in_valid && (op == srtf_pkg::OP_TICK);
    head       = '0;
    ctl.load     = (state == srtf_pkg::ST_IDLE) && in_valid && (op == srtf_pkg::OP_LOAD)
                   && slot_ok;
    ctl.clear    = (state == srtf_pkg::ST_IDLE) && in_valid && (op == srtf_pkg::OP_CLEAR);
    ctl.dec      = (state == srtf_pkg::ST_CALC) && best.found;
    ctl.wr_slot  = srtf_pkg::IDX_W'(in_slot);
    ctl.dec_slot = best.idx;
    ctl.arrival  = srtf_pkg::TIME_WIDTH'(in_arrival);
    ctl.burst    = srtf_pkg::TIME_WIDTH'(in_burst);
    ctl.now      = cur_time;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_time <= '0;
    end else if (accept && op == srtf_pkg::OP_CLEAR) begin
      cur_time <= '0;
    end else if (state == srtf_pkg::ST_CALC) begin
      cur_time <= time_inc;
    end
  end

  // finish time is known as soon as the tick is taken
  assign tat_calc  = (time_inc >= best.arr) ? time_inc - best.arr : '0;
  assign wait_calc = (res_tat >= best.burst) ? res_tat - best.burst : '0;

  always_ff @(posedge clk) begin
    if (accept) begin
      res_ran      <= 1'b0;
      res_fin      <= 1'b0;
      res_time_now <= cur_time;
      time_inc     <= (cur_time == srtf_pkg::TIME_MAX) ? srtf_pkg::TIME_MAX
                                                        : cur_time + srtf_pkg::time_t'(1);
    end else if (state == srtf_pkg::ST_CALC) begin
      res_ran      <= best.found;
      res_fin      <= best.found && (best.rem == srtf_pkg::time_t'(1));
      res_slot     <= best.idx;
      res_fin_time <= time_inc;
      res_tat      <= tat_calc;
    end
    if (state == srtf_pkg::ST_SCAN && tail_valid) begin
      best <= tail;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == srtf_pkg::ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == srtf_pkg::ST_EMIT && out_free) begin
      out_ran         <= res_ran;
      out_slot        <= res_ran ? srtf_pkg::SLOT_FIELD_W'(res_slot) : '0;
      out_finished    <= res_fin;
      out_finish_time <= res_fin ? srtf_pkg::FIELD_W'(res_fin_time) : '0;
      out_turnaround  <= res_fin ? srtf_pkg::FIELD_W'(res_tat) : '0;
      out_waiting     <= res_fin ? srtf_pkg::FIELD_W'(wait_calc) : '0;
      out_time_now    <= srtf_pkg::FIELD_W'(res_time_now);
    end
  end

  `SRTF_ASSERT_IMPLY(a_tail_in_scan, clk, rst, tail_valid, state == srtf_pkg::ST_SCAN)
  `SRTF_ASSERT_IMPLY(a_dec_nonempty, clk, rst, ctl.dec, best.rem != '0)
  `SRTF_ASSERT_NEVER(a_one_cell_op, clk, rst, ctl.load && (ctl.clear || ctl.dec))
  `SRTF_ASSERT_IMPLY(a_fin_ran, clk, rst, out_valid && out_finished, out_ran)
  `SRTF_ASSERT_NEXT(a_tick_scans, clk, rst, head_valid, state == srtf_pkg::ST_SCAN)

endmodule

### rtl/srtf_preemptive_scheduler_top.sv
// ----------------------------------------------------------------------------
// SRTF preemptive scheduler, top level
// Shortest-remaining-time-first scheduler over a row of slot cells.
// ----------------------------------------------------------------------------
//  channel   direction  carries
//  s_*       in         item: opcode (tuser), slot, arrival, burst (tdata)
//  m_*       out        item: ran, finished (tuser), slot and times (tdata)
//
//  In a tick item the best candidate walks the cell row one cell per cycle,
//  starting in the accept cycle; the sequencer then captures the tail, does
//  the update and turnaround, and fills the output register.
//  Load, clear and no-op items go from the accept straight to the output fill.
//  One item is in flight at a time; the next is taken while a result waits.
//  Reset empties every slot and zeroes time; a stalled m_tready holds the
//  finished item and the sequencer waits before writing the next one.
// ----------------------------------------------------------------------------
module srtf_preemptive_scheduler_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // slot[3:0], arrival_time[19:4], burst_time[35:20]
  input  logic [1:0]  s_tuser,   // opcode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // running_slot[3:0], finish_time[19:4],
                                 // turnaround[35:20], waiting_time[51:36],
                                 // time_now[67:52]
  output logic [1:0]  m_tuser    // ran[0], finished[1]
);

  // candidate chain: entry 0 is the head from the sequencer, last is the tail
  logic                     chain_valid [srtf_pkg::SLOTS+1];
  srtf_pkg::cand_t          chain       [srtf_pkg::SLOTS+1];
  srtf_pkg::cell_ctl_t      ctl;

  logic                              out_ran;
  logic [srtf_pkg::SLOT_FIELD_W-1:0] out_slot;
  logic                              out_finished;
  logic [srtf_pkg::FIELD_W-1:0]      out_finish_time;
  logic [srtf_pkg::FIELD_W-1:0]      out_turnaround;
  logic [srtf_pkg::FIELD_W-1:0]      out_waiting;
  logic [srtf_pkg::FIELD_W-1:0]      out_time_now;

  srtf_seq u_seq (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .in_opcode       (s_tuser[1:0]),
    .in_slot         (s_tdata[3:0]),
    .in_arrival      (s_tdata[19:4]),
    .in_burst        (s_tdata[35:20]),
    .head_valid      (chain_valid[0]),
    .head            (chain[0]),
    .tail_valid      (chain_valid[srtf_pkg::SLOTS]),
    .tail            (chain[srtf_pkg::SLOTS]),
    .ctl             (ctl),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_ran         (out_ran),
    .out_slot        (out_slot),
    .out_finished    (out_finished),
    .out_finish_time (out_finish_time),
    .out_turnaround  (out_turnaround),
    .out_waiting     (out_waiting),
    .out_time_now    (out_time_now)
  );

  // one cell per slot; lower slots sit upstream so they win full ties
  for (genvar i = 0; i < srtf_pkg::SLOTS; i++) begin : g_cell
    srtf_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .idx        (srtf_pkg::IDX_W'(i)),
      .ctl        (ctl),
      .cin_valid  (chain_valid[i]),
      .cin        (chain[i]),
      .cout_valid (chain_valid[i+1]),
      .cout       (chain[i+1])
    );
  end

  assign m_tuser = {out_finished, out_ran};
  assign m_tdata = {4'b0000, out_time_now, out_waiting, out_turnaround,
                    out_finish_time, out_slot};

endmodule

### bench/tb_srtf_preemptive_scheduler_top.sv
// ----------------------------------------------------------------------------
// SRTF preemptive scheduler testbench
// Drives load, tick, clear and no-op items into the scheduler, keeps its own
// slot table and time counter, and checks every result field by field.
// ----------------------------------------------------------------------------
module tb_srtf_preemptive_scheduler_top;

  localparam int WATCHDOG_LIMIT = 1000;  // idle cycles before giving up
  localparam int DRAIN_CYCLES   = 25;    // longer than one tick item
  localparam int RANDOM_ITEMS   = 1750;

  typedef struct packed {
    logic            ran;
    srtf_pkg::idx_t  slot;
    logic            finished;
    srtf_pkg::time_t finish;
    srtf_pkg::time_t turnaround;
    srtf_pkg::time_t waiting;
    srtf_pkg::time_t now;
  } sched_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // slot[3:0], arrival_time[19:4], burst_time[35:20]
  logic [1:0]  s_tuser = '0;   // opcode[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;        // running_slot[3:0], finish_time[19:4],
                               // turnaround[35:20], waiting_time[51:36],
                               // time_now[67:52]
  logic [1:0]  m_tuser;        // ran[0], finished[1]

  // own copy of the slot table and clock
  srtf_pkg::time_t arrival_tab [srtf_pkg::SLOTS];
  srtf_pkg::time_t burst_tab   [srtf_pkg::SLOTS];
  srtf_pkg::time_t remain_tab  [srtf_pkg::SLOTS];
  srtf_pkg::time_t sched_clock;

  sched_result_t pending_results[$];

  bit gaps_on = 1'b1;          // random idling on both sides
  int errors = 0;
  int items_sent = 0;
  int ticks_ran = 0;
  int ticks_idle = 0;
  int completions = 0;
  int quiet_cycles = 0;

  srtf_preemptive_scheduler_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  function automatic srtf_pkg::time_t sat_step(srtf_pkg::time_t t);
    return (t == srtf_pkg::TIME_MAX) ? srtf_pkg::TIME_MAX : t + 1'b1;
  endfunction

  function automatic void clear_table();
    for (int s = 0; s < srtf_pkg::SLOTS; s++) begin
      arrival_tab[s] = '0;
      burst_tab[s]   = '0;
      remain_tab[s]  = '0;
    end
    sched_clock = '0;
  endfunction

  // Applies one item to the table and returns the result it should produce.
  function automatic sched_result_t schedule_item(srtf_pkg::op_e op, srtf_pkg::idx_t slot,
                                                   srtf_pkg::time_t arr,
                                                   srtf_pkg::time_t bur);
    sched_result_t   r;
    int              best;
    logic            found;
    srtf_pkg::time_t fin;
    srtf_pkg::time_t tat;
    r     = '0;
    r.now = sched_clock;
    best  = 0;
    found = 1'b0;
    case (op)
      srtf_pkg::OP_LOAD: begin
        arrival_tab[slot] = arr;
        burst_tab[slot]   = bur;
        remain_tab[slot]  = bur;
      end
      srtf_pkg::OP_TICK: begin
        for (int s = 0; s < srtf_pkg::SLOTS; s++) begin
          if (remain_tab[s] != '0 && arrival_tab[s] <= sched_clock) begin
            // shorter remaining wins, then earlier arrival, then lower slot
            if (!found || remain_tab[s] < remain_tab[best] ||
                (remain_tab[s] == remain_tab[best] &&
                 arrival_tab[s] < arrival_tab[best])) begin
              best  = s;
              found = 1'b1;
            end
          end
        end
        if (found) begin
          r.ran  = 1'b1;
          r.slot = srtf_pkg::idx_t'(best);
          remain_tab[best] = remain_tab[best] - 1'b1;
          if (remain_tab[best] == '0) begin
            fin = sat_step(sched_clock);
            tat = (fin >= arrival_tab[best]) ? fin - arrival_tab[best] : '0;
            r.finished   = 1'b1;
            r.finish     = fin;
            r.turnaround = tat;
            r.waiting    = (tat >= burst_tab[best]) ? tat - burst_tab[best] : '0;
          end
        end
        sched_clock = sat_step(sched_clock);
      end
      srtf_pkg::OP_CLEAR: clear_table();
      default: ;
    endcase
    return r;
  endfunction

  // Sends one item, then books the result it should cause.
  task automatic send_item(srtf_pkg::op_e op, srtf_pkg::idx_t slot, srtf_pkg::time_t arr,
                           srtf_pkg::time_t bur);
    int            gap;
    sched_result_t r;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, bur, arr, slot};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    r = schedule_item(op, slot, arr, bur);
    pending_results.push_back(r);
    items_sent++;
    if (op == srtf_pkg::OP_TICK) begin
      if (r.ran) ticks_ran++;
      else ticks_idle++;
      if (r.finished) completions++;
    end
  endtask

  // result side back-pressure
  initial begin : sink_stall
    int n;
    @(negedge rst);
    forever begin
      n = gaps_on ? $urandom_range(0, 3) : 0;
      if (n != 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
      errors++;
    end
  endtask

  // every accepted result against the oldest booked one
  always @(posedge clk) begin : result_check
    sched_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual tdata %0h tuser %0h",
                 $realtime, m_tdata, m_tuser);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("ran", 16'(want.ran), 16'(m_tuser[0]));
        check_field("finished", 16'(want.finished), 16'(m_tuser[1]));
        check_field("running_slot", 16'(want.slot), 16'(m_tdata[3:0]));
        check_field("finish_time", 16'(want.finish), m_tdata[19:4]);
        check_field("turnaround", 16'(want.turnaround), m_tdata[35:20]);
        check_field("waiting_time", 16'(want.waiting), m_tdata[51:36]);
        check_field("time_now", 16'(want.now), m_tdata[67:52]);
      end
    end
  end

  // cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding",
               $realtime, pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // empty table, empty loads, no-op, not-yet-arrived process
  task automatic test_idle_and_extremes();
    send_item(srtf_pkg::OP_TICK, 4'd0, '0, '0);
    send_item(srtf_pkg::OP_LOAD, 4'd0, '0, '0);          // burst 0 keeps the slot empty
    send_item(srtf_pkg::OP_TICK, 4'd0, '0, '0);
    send_item(srtf_pkg::OP_NOP, 4'd15, srtf_pkg::TIME_MAX, srtf_pkg::TIME_MAX);
    send_item(srtf_pkg::OP_TICK, 4'd0, '0, '0);
    send_item(srtf_pkg::OP_LOAD, 4'd15, srtf_pkg::TIME_MAX, srtf_pkg::TIME_MAX);
    send_item(srtf_pkg::OP_TICK, 4'd0, '0, '0);          // slot 15 not arrived yet
    send_item(srtf_pkg::OP_CLEAR, 4'd15, srtf_pkg::TIME_MAX, srtf_pkg::TIME_MAX);
  endtask

  // tie on remaining time, tie on arrival, reload of a running slot
  task automatic test_ties_and_reload();
    send_item(srtf_pkg::OP_LOAD, 4'd9, 16'd0, 16'd3);
    send_item(srtf_pkg::OP_LOAD, 4'd2, 16'd1, 16'd2);
    send_item(srtf_pkg::OP_LOAD, 4'd5, 16'd1, 16'd2);
    repeat (4) send_item(srtf_pkg::OP_TICK, 4'd0, '0, '0);
    send_item(srtf_pkg::OP_LOAD, 4'd2, 16'd0, 16'd4);    // slot 2 reloaded mid-run
    send_item(srtf_pkg::OP_LOAD, 4'd15, 16'd0, 16'd1);
    repeat (6) send_item(srtf_pkg::OP_TICK, 4'd0, '0, '0);
    send_item(srtf_pkg::OP_CLEAR, 4'd0, '0, '0);
  endtask

  // mostly short processes arriving near the current time, ticks between
  task automatic test_random_schedule();
    int              pick;
    int              a;
    srtf_pkg::idx_t  slot;
    srtf_pkg::time_t arr;
    srtf_pkg::time_t bur;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 250 == 0) gaps_on = (i % 500 == 0);
      pick = $urandom_range(0, 99);
      slot = srtf_pkg::idx_t'($urandom_range(0, srtf_pkg::SLOTS - 1));
      arr  = srtf_pkg::time_t'($urandom);
      bur  = srtf_pkg::time_t'($urandom);
      if (pick < 2) begin
        send_item(srtf_pkg::OP_CLEAR, slot, arr, bur);
      end else if (pick < 5) begin
        send_item(srtf_pkg::OP_NOP, slot, arr, bur);
      end else if (pick < 33) begin
        case ($urandom_range(0, 9))
          0:       ;                           // arrival anywhere
          1:       arr = '0;
          default: begin
            a   = int'(sched_clock) + int'($urandom_range(0, 6));
            arr = (a > int'(srtf_pkg::TIME_MAX)) ? srtf_pkg::TIME_MAX
                                                  : srtf_pkg::time_t'(a);
          end
        endcase
        case ($urandom_range(0, 9))
          0:       ;                           // any burst
          1:       bur = '0;
          2:       bur = srtf_pkg::time_t'($urandom_range(7, 40));
          default: bur = srtf_pkg::time_t'($urandom_range(1, 6));
        endcase
        send_item(srtf_pkg::OP_LOAD, slot, arr, bur);
      end else begin
        send_item(srtf_pkg::OP_TICK, slot, arr, bur);
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    clear_table();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_idle_and_extremes();
    test_ties_and_reload();
    test_random_schedule();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d items: %0d ticks ran, %0d idle ticks, %0d completions,",
             items_sent, ticks_ran, ticks_idle, completions);
    $display("including ties, reloads, empty loads and processes not yet arrived.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
